[hw/rtl/mvb_pkg.sv]
// mvb_pkg: shared widths, payload structs, sequencer states and unit control
// for the MUSCL / van Leer Burgers right-hand-side block. No dependencies.
package mvb_pkg;

  localparam int VALUE_W = 32;               // Q8.24 cell and face values
  localparam int FRAC_W  = 24;               // fraction bits of values and edges
  localparam int EDGE_W  = FRAC_W + 1;       // Q1.24 edge positions
  localparam int DZ_W    = EDGE_W + 1;       // signed edge differences
  localparam int DIFF_W  = VALUE_W + 1;      // signed value differences
  localparam int RATE_W  = 48;               // Q24.24 rate
  localparam int GAIN_W  = 32;               // Q8.24 flux gain
  localparam int FLUX_W  = 63;               // flux, capped at 2^62

  localparam int PW_NUM  = 2 * DIFF_W + DZ_W;
  localparam int PW_FLX  = 2 * VALUE_W + GAIN_W;
  localparam int PW_RATE = FLUX_W + FRAC_W;
  localparam int PW_AB   = (PW_NUM > PW_FLX) ? PW_NUM : PW_FLX;
  localparam int PW      = ((PW_AB > PW_RATE) ? PW_AB : PW_RATE) + 1;

  localparam int CNT_W   = 8;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_W;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cell_value;
    logic [EDGE_W-1:0]         right_edge;
    logic                      last_cell;
  } mvb_in_t;

  typedef struct packed {
    logic signed [RATE_W-1:0]  rate_value;
    logic signed [VALUE_W-1:0] face_value;
    logic                      row_end;
    logic                      grid_error;
    logic                      clipped;
  } mvb_out_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mvb_op_t;

  typedef struct packed {
    logic             start;
    mvb_op_t          op;
    logic [CNT_W-1:0] count;
  } mvb_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_AC,
    ST_MUL_NUM,
    ST_MUL_AQ,
    ST_MUL_CP,
    ST_DIV_OFF,
    ST_FACE,
    ST_MUL_SQ,
    ST_MUL_GAIN,
    ST_FLUX,
    ST_DIV_RATE,
    ST_EMIT
  } mvb_state_t;

endpackage

[hw/rtl/mvb_iter_unit.sv]
// mvb_iter_unit: shared bit-serial shift-add multiplier and restoring divider
// around one wide adder. Depends on mvb_pkg.
module mvb_iter_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mvb_pkg::mvb_ctrl_t      ctrl,
  input  logic [mvb_pkg::PW-1:0]  opa,
  input  logic [mvb_pkg::PW-1:0]  opb,
  input  logic [mvb_pkg::PW-1:0]  opc,
  output logic                    busy,
  output logic [mvb_pkg::PW-1:0]  result,
  output logic                    ovf
);

  localparam int PW = mvb_pkg::PW;

  logic                      busy_r, busy_nxt;
  mvb_pkg::mvb_op_t          op_r, op_nxt;
  logic [mvb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]             x_r, x_nxt;
  logic [PW-1:0]             y_r, y_nxt;
  logic [PW-1:0]             z_r, z_nxt;
  logic                      ovf_r, ovf_nxt;

  logic [PW-1:0] shifted;
  logic [PW-1:0] add_a;
  logic [PW-1:0] add_b;
  logic [PW:0]   sum;
  logic          is_div;
  logic          ge;

  // Multiply: x accumulates, y is the shifted multiplicand, z the multiplier.
  // Divide: x is the remainder, y the divisor, z feeds numerator bits in at
  // the top and collects quotient bits at the bottom.
  always_comb begin
    is_div  = (op_r == mvb_pkg::OP_DIV);
    shifted = {x_r[PW-2:0], z_r[PW-1]};
    add_a   = is_div ? shifted : x_r;
    add_b   = is_div ? ~y_r : y_r;
    sum     = {1'b0, add_a} + {1'b0, add_b} + {{PW{1'b0}}, is_div};
    ge      = is_div & sum[PW];
  end

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    ovf_nxt  = ovf_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctrl.op;
      cnt_nxt  = ctrl.count;
      if (ctrl.op == mvb_pkg::OP_DIV) begin
        x_nxt   = opa;
        y_nxt   = opb;
        z_nxt   = opc;
        ovf_nxt = (opa >= opb);
      end else begin
        x_nxt   = opc;
        y_nxt   = opa;
        z_nxt   = opb;
        ovf_nxt = 1'b0;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == mvb_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
      if (is_div) begin
        x_nxt = ge ? sum[PW-1:0] : shifted;
        z_nxt = {z_r[PW-2:0], ge};
      end else begin
        x_nxt = z_r[0] ? sum[PW-1:0] : x_r;
        y_nxt = {y_r[PW-2:0], 1'b0};
        z_nxt = {1'b0, z_r[PW-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= mvb_pkg::OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy   = busy_r;
  assign result = is_div ? z_r : x_r;
  assign ovf    = ovf_r;

endmodule

[hw/rtl/muscl_vanleer_burgers_rhs_top.sv]
// muscl_vanleer_burgers_rhs_top: streaming MUSCL / van Leer upwind right-hand
// side for Burgers flux. Depends on mvb_pkg and mvb_iter_unit.
//
// Usage:
//   in_*  : one word per cell: Q8.24 cell average, Q1.24 right edge, last mark.
//   out_* : one word per finished cell: Q24.24 du/dt, Q8.24 upwind face value,
//           row end, grid error and saturation flags.
//   cfg_* : one write-only word, the Q8.24 flux gain (1.0 after reset).
//           Write it only while the block is idle.
//   A cell finishes when its right neighbor arrives, so results trail by one
//   word; a word with last_cell set also finishes itself and restarts the row.
//   An input word thus yields zero, one or two output words.
//   A finished cell takes longer when the limited slope is worked out than when
//   it is zero or the cell is the row's last. The
//   cost is set by the shared iterative unit: six bit-serial multiplies and
//   two restoring divides, one bit per cycle. in_ready is high only in idle,
//   so a new input word waits until every result of the last one is emitted.
//   Results sit in an output register; a stalled receiver holds the sequencer
//   in its emit step, and the next result waits until the register is taken.
//   Reset (rst_n low, synchronous) clears the row state, empties the output
//   register and loads the gain with 1.0.
module muscl_vanleer_burgers_rhs_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mvb_pkg::mvb_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mvb_pkg::mvb_out_t    out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [mvb_pkg::GAIN_W-1:0] cfg_data
);

  localparam int PW     = mvb_pkg::PW;
  localparam int VW     = mvb_pkg::VALUE_W;
  localparam int FW     = mvb_pkg::FRAC_W;
  localparam int EW     = mvb_pkg::EDGE_W;
  localparam int DZW    = mvb_pkg::DZ_W;
  localparam int DFW    = mvb_pkg::DIFF_W;
  localparam int RW     = mvb_pkg::RATE_W;
  localparam int HW     = mvb_pkg::FLUX_W;
  localparam int GW     = mvb_pkg::GAIN_W;
  localparam int CW     = mvb_pkg::CNT_W;

  localparam logic [VW:0]   OFF_CAP   = (VW+1)'(1) << VW;
  localparam logic [HW-1:0] H_CAP     = HW'(1) << (HW - 1);
  localparam logic [RW-1:0] RCAP_NEG  = {1'b0, {(RW-1){1'b1}}};
  localparam logic [RW-1:0] RCAP_POS  = RW'(1) << (RW - 1);
  localparam logic [EW-1:0] EDGE_ONE  = EW'(1) << FW;
  localparam logic signed [VW-1:0] FMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] FMIN = {1'b1, {(VW-1){1'b0}}};

  // sequencer and handshake state
  mvb_pkg::mvb_state_t state_r, state_nxt;
  logic                wait_r;
  logic                end_call_r;
  logic                out_valid_r;
  mvb_pkg::mvb_out_t   out_data_r;
  logic [GW-1:0]       gain_r;

  // row state
  mvb_pkg::mvb_in_t       in_r;
  logic signed [VW-1:0]   prior_value_r;
  logic [EW-1:0]          prior_left_r;
  logic signed [VW-1:0]   pend_value_r;
  logic [EW-1:0]          pend_left_r;
  logic [EW-1:0]          pend_right_r;
  logic                   pend_valid_r;
  logic [HW-1:0]          influx_r;

  // per-cell working registers
  logic [PW-1:0]          num_r;
  logic [PW-1:0]          den_r;
  logic [VW:0]            off_r;
  logic signed [VW-1:0]   face_r;
  logic                   clip_r;
  logic [HW-1:0]          h_r;
  logic [RW-1:0]          rate_r;

  // shared unit
  mvb_pkg::mvb_ctrl_t  ctrl;
  logic [PW-1:0]       opa, opb, opc;
  logic                busy;
  logic [PW-1:0]       result;
  logic                ovf;

  // datapath
  logic signed [VW-1:0]  nx_value;
  logic [EW-1:0]         nx_right;
  logic signed [DZW-1:0] dz, p, q;
  logic signed [DFW-1:0] a, c;
  logic [DFW-1:0]        aa, cc;
  logic                  dz_pos, cond;
  logic signed [VW+1:0]  fsum;
  logic signed [VW-1:0]  face_sat;
  logic                  face_clip;
  logic [VW-1:0]         fmag;
  logic [PW-1:0]         hs;
  logic [HW-1:0]         h_new;
  logic signed [HW:0]    d;
  logic                  d_pos;
  logic [HW-1:0]         dm;
  logic [PW-1:0]         rnum;
  logic [VW:0]           q_off;
  logic [RW-1:0]         q_rate, rcap, q_sel;
  logic                  rate_clip;
  logic                  arith_st, unit_done, slot_free;
  logic                  grid_err;

  mvb_iter_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .opa    (opa),
    .opb    (opb),
    .opc    (opc),
    .busy   (busy),
    .result (result),
    .ovf    (ovf)
  );

  // Cell b is the pending cell; b-1 the prior one; b+1 the latched input word,
  // or inflow zero at the row's end.
  always_comb begin
    nx_value = end_call_r ? '0 : in_r.cell_value;
    nx_right = end_call_r ? '0 : in_r.right_edge;
    dz = $signed({1'b0, pend_right_r}) - $signed({1'b0, pend_left_r});
    p  = $signed({1'b0, pend_right_r}) - $signed({1'b0, prior_left_r});
    q  = $signed({1'b0, nx_right}) - $signed({1'b0, pend_left_r});
    a  = $signed({pend_value_r[VW-1], pend_value_r})
       - $signed({prior_value_r[VW-1], prior_value_r});
    c  = $signed({nx_value[VW-1], nx_value}) - $signed({pend_value_r[VW-1], pend_value_r});
    aa = a[DFW-1] ? (~a + 1'b1) : a;
    cc = c[DFW-1] ? (~c + 1'b1) : c;
    dz_pos = !dz[DZW-1] && (dz != '0);
    cond = !end_call_r && dz_pos
        && !p[DZW-1] && (p != '0)
        && !q[DZW-1] && (q != '0)
        && (a != '0) && (c != '0) && (a[DFW-1] == c[DFW-1]);
    grid_err = !dz_pos || (end_call_r && (pend_right_r != EDGE_ONE));
  end

  // Face: apply the clamped offset on the side of the slope, then saturate.
  always_comb begin
    if (a[DFW-1]) begin
      fsum = $signed({{2{pend_value_r[VW-1]}}, pend_value_r}) - $signed({1'b0, off_r});
    end else begin
      fsum = $signed({{2{pend_value_r[VW-1]}}, pend_value_r}) + $signed({1'b0, off_r});
    end
    face_clip = !((fsum[VW+1:VW-1] == 3'b000) || (fsum[VW+1:VW-1] == 3'b111));
    if (!face_clip) begin
      face_sat = fsum[VW-1:0];
    end else if (fsum[VW+1]) begin
      face_sat = FMIN;
    end else begin
      face_sat = FMAX;
    end
    fmag = face_r[VW-1] ? (~face_r + 1'b1) : face_r;
  end

  // Flux, flux difference and quotient clamps.
  always_comb begin
    hs    = result >> (2 * FW + 1);
    h_new = ((hs[PW-1:HW] != '0) || (hs[HW-1:0] > H_CAP)) ? H_CAP : hs[HW-1:0];
    d     = $signed({1'b0, h_r}) - $signed({1'b0, influx_r});
    d_pos = !d[HW] && (d != '0);
    dm    = d[HW] ? HW'(~d + 1'b1) : d[HW-1:0];
    rnum  = PW'(dm) << FW;
    q_off = (ovf || (result[VW:0] > OFF_CAP)) ? OFF_CAP : result[VW:0];
    q_rate    = result[RW-1:0];
    rcap      = d_pos ? RCAP_POS : RCAP_NEG;
    rate_clip = ovf || (q_rate > rcap);
    q_sel     = rate_clip ? rcap : q_rate;
  end

  assign arith_st  = (state_r == mvb_pkg::ST_MUL_AC) || (state_r == mvb_pkg::ST_MUL_NUM)
                  || (state_r == mvb_pkg::ST_MUL_AQ) || (state_r == mvb_pkg::ST_MUL_CP)
                  || (state_r == mvb_pkg::ST_DIV_OFF) || (state_r == mvb_pkg::ST_MUL_SQ)
                  || (state_r == mvb_pkg::ST_MUL_GAIN) || (state_r == mvb_pkg::ST_DIV_RATE);
  assign unit_done = arith_st && wait_r && !busy;
  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mvb_pkg::ST_IDLE: begin
        if (in_valid && (pend_valid_r || in_data.last_cell)) begin
          state_nxt = mvb_pkg::ST_CHECK;
        end
      end
      mvb_pkg::ST_CHECK:    state_nxt = cond ? mvb_pkg::ST_MUL_AC : mvb_pkg::ST_FACE;
      mvb_pkg::ST_MUL_AC:   if (unit_done) state_nxt = mvb_pkg::ST_MUL_NUM;
      mvb_pkg::ST_MUL_NUM:  if (unit_done) state_nxt = mvb_pkg::ST_MUL_AQ;
      mvb_pkg::ST_MUL_AQ:   if (unit_done) state_nxt = mvb_pkg::ST_MUL_CP;
      mvb_pkg::ST_MUL_CP:   if (unit_done) state_nxt = mvb_pkg::ST_DIV_OFF;
      mvb_pkg::ST_DIV_OFF:  if (unit_done) state_nxt = mvb_pkg::ST_FACE;
      mvb_pkg::ST_FACE:     state_nxt = mvb_pkg::ST_MUL_SQ;
      mvb_pkg::ST_MUL_SQ:   if (unit_done) state_nxt = mvb_pkg::ST_MUL_GAIN;
      mvb_pkg::ST_MUL_GAIN: if (unit_done) state_nxt = mvb_pkg::ST_FLUX;
      mvb_pkg::ST_FLUX:     state_nxt = dz_pos ? mvb_pkg::ST_DIV_RATE : mvb_pkg::ST_EMIT;
      mvb_pkg::ST_DIV_RATE: if (unit_done) state_nxt = mvb_pkg::ST_EMIT;
      mvb_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = (!end_call_r && in_r.last_cell) ? mvb_pkg::ST_CHECK : mvb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mvb_pkg::ST_IDLE;
    endcase
  end

  // Unit commands and operands.
  always_comb begin
    ctrl.start = arith_st && !wait_r;
    ctrl.op    = mvb_pkg::OP_MUL;
    ctrl.count = '0;
    opa = '0;
    opb = '0;
    opc = '0;
    case (state_r)
      mvb_pkg::ST_MUL_AC: begin
        opa = PW'(aa);
        opb = PW'(cc);
        ctrl.count = CW'(DFW);
      end
      mvb_pkg::ST_MUL_NUM: begin
        opa = num_r;
        opb = PW'({dz[DZW-2:0], 1'b0});
        ctrl.count = CW'(DZW);
      end
      mvb_pkg::ST_MUL_AQ: begin
        opa = PW'(aa);
        opb = PW'(q[DZW-2:0]);
        ctrl.count = CW'(EW);
      end
      mvb_pkg::ST_MUL_CP: begin
        opa = PW'(cc);
        opb = PW'(p[DZW-2:0]);
        opc = den_r;
        ctrl.count = CW'(EW);
      end
      mvb_pkg::ST_DIV_OFF: begin
        ctrl.op = mvb_pkg::OP_DIV;
        opa = num_r >> (VW + 1);
        opb = den_r;
        opc = num_r << (PW - VW - 1);
        ctrl.count = CW'(VW + 1);
      end
      mvb_pkg::ST_MUL_SQ: begin
        opa = PW'(fmag);
        opb = PW'(fmag);
        ctrl.count = CW'(VW);
      end
      mvb_pkg::ST_MUL_GAIN: begin
        opa = num_r;
        opb = PW'(gain_r);
        ctrl.count = CW'(GW);
      end
      mvb_pkg::ST_DIV_RATE: begin
        ctrl.op = mvb_pkg::OP_DIV;
        opa = rnum >> RW;
        opb = PW'(dz[DZW-2:0]);
        opc = rnum << (PW - RW);
        ctrl.count = CW'(RW);
      end
      default: begin
        ctrl.count = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvb_pkg::ST_IDLE;
      wait_r      <= 1'b0;
      end_call_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= mvb_pkg::GAIN_RESET;
      pend_valid_r  <= 1'b0;
      prior_value_r <= '0;
      prior_left_r  <= '0;
      pend_value_r  <= '0;
      pend_left_r   <= '0;
      pend_right_r  <= '0;
      influx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        gain_r <= cfg_data;
      end
      if (arith_st && !wait_r) begin
        wait_r <= 1'b1;
      end else if (unit_done) begin
        wait_r <= 1'b0;
      end
      // load a new result word, or drop the old one once taken
      if ((state_r == mvb_pkg::ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        mvb_pkg::ST_IDLE: begin
          if (in_valid) begin
            if (pend_valid_r) begin
              end_call_r <= 1'b0;
            end else begin
              // first cell of a row: open it at the left boundary
              pend_value_r <= in_data.cell_value;
              pend_left_r  <= '0;
              pend_right_r <= in_data.right_edge;
              pend_valid_r <= 1'b1;
              end_call_r   <= in_data.last_cell;
            end
          end
        end
        mvb_pkg::ST_EMIT: begin
          if (slot_free) begin
            if (!end_call_r) begin
              // advance the window by one cell
              prior_value_r <= pend_value_r;
              prior_left_r  <= pend_left_r;
              influx_r      <= h_r;
              pend_value_r  <= in_r.cell_value;
              pend_left_r   <= pend_right_r;
              pend_right_r  <= in_r.right_edge;
              end_call_r    <= in_r.last_cell;
            end else begin
              // row done: restart with zero flux and zero inflow
              prior_value_r <= '0;
              prior_left_r  <= '0;
              pend_value_r  <= '0;
              pend_left_r   <= '0;
              pend_right_r  <= '0;
              influx_r      <= '0;
              pend_valid_r  <= 1'b0;
              end_call_r    <= 1'b0;
            end
          end
        end
        default: begin
          end_call_r <= end_call_r;
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if ((state_r == mvb_pkg::ST_IDLE) && in_valid) begin
      in_r <= in_data;
    end
    case (state_r)
      mvb_pkg::ST_CHECK: begin
        off_r <= '0;
      end
      mvb_pkg::ST_MUL_AC, mvb_pkg::ST_MUL_NUM, mvb_pkg::ST_MUL_SQ, mvb_pkg::ST_MUL_GAIN: begin
        if (unit_done) num_r <= result;
      end
      mvb_pkg::ST_MUL_AQ, mvb_pkg::ST_MUL_CP: begin
        if (unit_done) den_r <= result;
      end
      mvb_pkg::ST_DIV_OFF: begin
        if (unit_done) off_r <= q_off;
      end
      mvb_pkg::ST_FACE: begin
        face_r <= face_sat;
        clip_r <= face_clip;
      end
      mvb_pkg::ST_FLUX: begin
        h_r    <= h_new;
        rate_r <= '0;
      end
      mvb_pkg::ST_DIV_RATE: begin
        if (unit_done) begin
          rate_r <= d_pos ? (~q_sel + 1'b1) : q_sel;
          clip_r <= clip_r | rate_clip;
        end
      end
      mvb_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_data_r.rate_value <= rate_r;
          out_data_r.face_value <= face_r;
          out_data_r.row_end    <= end_call_r;
          out_data_r.grid_error <= grid_err;
          out_data_r.clipped    <= clip_r;
        end
      end
      default: begin
        clip_r <= clip_r;
      end
    endcase
  end

  assign in_ready  = (state_r == mvb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

[test/mvb_scoreboard.sv]
// mvb_scoreboard: watches the input, config and result channels of the
// MUSCL / van Leer Burgers block, predicts each result and compares. Uses mvb_pkg.
`timescale 1ns / 1ps
module mvb_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  mvb_pkg::mvb_in_t   in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  mvb_pkg::mvb_out_t  out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 waiting
);

  mvb_pkg::mvb_out_t rhs_q[$];
  logic [31:0] gain;
  logic signed [63:0] up_val, cur_val;
  logic [63:0] up_left, cur_left, cur_right, flux_in;
  logic cur_ok, up_ok;

  // finish the pending cell; returns its outgoing flux
  function automatic logic [63:0] close_cell(input logic signed [63:0] uv,
      input logic [63:0] ul, input logic signed [63:0] nv, input logic [63:0] nr,
      input logic at_end, output mvb_pkg::mvb_out_t r);
    logic signed [63:0] dz, p, q, a, c, face, d;
    logic [127:0] num, den, off, fsq, quo;
    logic [63:0] fm, h, dm, cap;
    logic clip;
    clip = 1'b0;
    dz = $signed(cur_right) - $signed(cur_left);
    p = $signed(cur_right) - $signed(ul);
    q = $signed(nr) - $signed(cur_left);
    a = cur_val - uv;
    c = nv - cur_val;
    off = '0;
    if (!at_end && dz > 0 && p > 0 && q > 0 && a != 0 && c != 0 && ((a < 0) == (c < 0))) begin
      num = 128'(a < 0 ? -a : a) * 128'(c < 0 ? -c : c) * 128'(2 * dz);
      den = 128'(a < 0 ? -a : a) * 128'(q) + 128'(c < 0 ? -c : c) * 128'(p);
      off = num / den;
      if (off > (128'd1 << 32)) off = 128'd1 << 32;
    end
    face = (a < 0) ? cur_val - $signed(off[63:0]) : cur_val + $signed(off[63:0]);
    if (face > 64'sd2147483647) begin face = 64'sd2147483647; clip = 1'b1; end
    if (face < -64'sd2147483648) begin face = -64'sd2147483648; clip = 1'b1; end
    fm = face < 0 ? -face : face;
    fsq = (128'(fm) * 128'(fm) * 128'(gain)) >> 49;
    h = (fsq > (128'd1 << 62)) ? (64'd1 << 62) : fsq[63:0];
    r.rate_value = '0;
    if (dz > 0) begin
      d = $signed(h) - $signed(flux_in);
      dm = d < 0 ? -d : d;
      quo = (128'(dm) << 24) / 128'(dz);
      cap = (64'd1 << 47) - 1 + (d > 0 ? 64'd1 : 64'd0);
      if (quo > 128'(cap)) begin quo = 128'(cap); clip = 1'b1; end
      r.rate_value = d > 0 ? -quo[47:0] : quo[47:0];
    end
    r.face_value = face[31:0];
    r.row_end = at_end;
    r.grid_error = (dz <= 0) || (at_end && cur_right != (64'd1 << 24));
    r.clipped = clip;
    return h;
  endfunction

  function automatic string show(input mvb_pkg::mvb_out_t r);
    return $sformatf("rate=%0d face=%0d end=%0b gerr=%0b clip=%0b", r.rate_value,
                     r.face_value, r.row_end, r.grid_error, r.clipped);
  endfunction

  assign waiting = rhs_q.size();

  always_ff @(posedge clk) begin
    mvb_pkg::mvb_out_t r, e;
    logic [63:0] h;
    logic signed [63:0] v;
    logic [63:0] nleft;
    if (!rst_n) begin
      gain <= mvb_pkg::GAIN_RESET;
      {up_val, cur_val, up_left, cur_left, cur_right, flux_in} = '0;
      cur_ok = 1'b0;
      up_ok = 1'b0;
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) gain <= cfg_data;
      if (in_valid && in_ready) begin
        // blocking copies let both results of one word see updated state
        v = 64'(in_data.cell_value);
        nleft = '0;
        if (cur_ok) begin
          h = close_cell(up_ok ? up_val : 0, up_ok ? up_left : 0, v,
                         64'(in_data.right_edge), 1'b0, r);
          rhs_q.push_back(r);
          up_val = cur_val; up_left = cur_left; up_ok = 1'b1; flux_in = h;
          nleft = cur_right;
        end
        cur_val = v; cur_left = nleft; cur_right = 64'(in_data.right_edge); cur_ok = 1'b1;
        if (in_data.last_cell) begin
          h = close_cell(up_ok ? up_val : 0, up_ok ? up_left : 0, 0, 0, 1'b1, r);
          rhs_q.push_back(r);
          {up_val, cur_val, up_left, cur_left, cur_right, flux_in} = '0;
          cur_ok = 1'b0; up_ok = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (rhs_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %s", $time, show(out_data));
          errors <= errors + 1;
        end else begin
          e = rhs_q.pop_front();
          if (out_data !== e) begin
            $display("%0t: mismatch: expected %s, actual %s", $time, show(e), show(out_data));
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

[test/muscl_vanleer_burgers_rhs_top_tb.sv]
// muscl_vanleer_burgers_rhs_top_tb: drives rows of cells and gain writes into
// the block; mvb_scoreboard does the checking. Uses mvb_pkg and the block RTL.
`timescale 1ns / 1ps
module muscl_vanleer_burgers_rhs_top_tb;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  mvb_pkg::mvb_in_t in_data;
  mvb_pkg::mvb_out_t out_data;
  logic [mvb_pkg::GAIN_W-1:0] cfg_data;
  int errors, waiting;
  logic calm;      // no idling in the closing stretch

  muscl_vanleer_burgers_rhs_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data);

  mvb_scoreboard board (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data, .errors, .waiting);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: stall in random bursts, none once calm
  initial begin
    int gap;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // send one word and wait for its handshake; valid stays up for the next word
  task automatic send_cell(input logic [31:0] val, input logic [24:0] edge_pos,
                           input logic last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cell_value: val, right_edge: edge_pos, last_cell: last};
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait until every expected result has arrived, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_gain(input logic [31:0] g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  // n cells on a random, mostly well-formed grid; a row may also end early
  task automatic send_row(input int n);
    logic [24:0] pos, step;
    logic signed [31:0] base;
    base = pick_value();
    pos = '0;
    for (int i = 0; i < n; i++) begin
      step = 25'($urandom_range(1, (25'd1 << 24) / n));
      pos = (i == n - 1) ? 25'd1 << 24 : pos + step;
      if ($urandom_range(0, 15) == 0) pos = 25'($urandom_range(0, 25'h1ffffff));
      base = ($urandom_range(0, 3) == 0) ? pick_value()
           : base + 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0008_0000);
      send_cell(base, pos, (i == n - 1) || $urandom_range(0, 40) == 0);
    end
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, single-cell rows, bad edges, flat and monotone runs
    send_cell(32'h7fffffff, 25'd1 << 24, 1'b1);
    send_cell(32'h80000000, 25'd1 << 24, 1'b1);
    send_cell(32'h01000000, 25'h1ffffff, 1'b1);
    send_cell(32'h01000000, 25'd0, 1'b0);
    send_cell(32'h02000000, 25'd0, 1'b0);
    send_cell(32'h03000000, 25'h400000, 1'b1);
    send_cell(32'h01000000, 25'h400000, 1'b0);
    send_cell(32'h02000000, 25'h800000, 1'b0);
    send_cell(32'h03000000, 25'hc00000, 1'b0);
    send_cell(32'h03000000, 25'h1000000, 1'b1);
    send_cell(32'hff000000, 25'h000001, 1'b0);
    send_cell(32'hfe000000, 25'h000002, 1'b0);
    send_cell(32'h80000000, 25'h1000000, 1'b1);
    send_cell(32'h7fffffff, 25'h000001, 1'b0);
    send_cell(32'h80000000, 25'h000002, 1'b0);
    send_cell(32'h7fffffff, 25'h1000000, 1'b1);
    drain();

    // gain extremes, with short rows after each
    write_gain(32'hffffffff);
    send_cell(32'h7fffffff, 25'h000001, 1'b0);
    send_cell(32'h7fffffff, 25'h1000000, 1'b1);
    send_row(4);
    drain();
    write_gain(32'h0);
    send_row(4);
    drain();

    sent = 0;
    while (sent < 560) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_gain($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0400_0000));
      end
      if (sent > 460) calm = 1'b1;
      send_row(n);
      sent += n;
    end

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // the worst case for all words plus stalls and drains stays far below this
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
